// ===== src/lws_pkg.sv =====
package lws_pkg;

  localparam int CNT_W   = 32;
  localparam int TOTAL_W = 48;
  localparam int LAT_W   = 32;
  localparam int PER_W   = 16;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 4;
  localparam int WIN_W   = 2;

  localparam logic [CNT_W-1:0]   CNT_MAX   = '1;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;
  localparam logic [LAT_W-1:0]   LAT_MAX   = '1;

  localparam logic [PER_W-1:0] PER_SHORT_RST = 16'd1000;
  localparam logic [PER_W-1:0] PER_LONG_RST  = 16'd5000;

  localparam logic [1:0] REG_ENABLE       = 2'd0;
  localparam logic [1:0] REG_SHORT_PERIOD = 2'd1;
  localparam logic [1:0] REG_LONG_PERIOD  = 2'd2;

  typedef enum logic [1:0] {
    ACT_RECORD = 2'd0,
    ACT_TICK   = 2'd1,
    ACT_CLEAR  = 2'd2,
    ACT_REPORT = 2'd3
  } act_e;

  typedef enum logic [WIN_W-1:0] {
    WIN_ALL   = 2'd0,
    WIN_SHORT = 2'd1,
    WIN_LONG  = 2'd2
  } win_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REC_ALL,
    ST_REC_SHORT,
    ST_REC_LONG,
    ST_RD,
    ST_MRG,
    ST_DIV_GO,
    ST_DIV_WAIT
  } state_e;

  typedef struct packed {
    logic [CNT_W-1:0]   count;
    logic [TOTAL_W-1:0] total;
    logic [LAT_W-1:0]   least;
    logic [LAT_W-1:0]   greatest;
  } tally_t;

  localparam tally_t TALLY_RST = '{count: '0, total: '0, least: '1, greatest: '0};

  function automatic tally_t tally_merge(tally_t a, tally_t b);
    tally_t             y;
    logic [CNT_W:0]     c;
    logic [TOTAL_W:0]   t;
    c = {1'b0, a.count} + {1'b0, b.count};
    t = {1'b0, a.total} + {1'b0, b.total};
    y.count    = c[CNT_W] ? CNT_MAX : c[CNT_W-1:0];
    y.total    = t[TOTAL_W] ? TOTAL_MAX : t[TOTAL_W-1:0];
    y.least    = (b.least < a.least) ? b.least : a.least;
    y.greatest = (b.greatest > a.greatest) ? b.greatest : a.greatest;
    return y;
  endfunction

endpackage

// ===== src/lws_div.sv =====
module lws_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [lws_pkg::TOTAL_W-1:0] dividend_i,
  input  logic [lws_pkg::CNT_W-1:0]   divisor_i,
  output logic                      done_o,
  output logic [lws_pkg::TOTAL_W-1:0] quotient_o
);
  import lws_pkg::*;

  localparam int STEP_W = $clog2(TOTAL_W);

  logic               busy_q;
  logic               done_q;
  logic [STEP_W-1:0]  step_q;
  logic [CNT_W-1:0]   rem_q;
  logic [CNT_W-1:0]   div_q;
  logic [TOTAL_W-1:0] quo_q;
  logic [CNT_W:0]     trial;
  logic               fits;
  logic [CNT_W:0]     diff;
  logic [CNT_W-1:0]   rem_d;

  assign trial = {rem_q, quo_q[TOTAL_W-1]};
  assign fits  = trial >= {1'b0, div_q};
  assign diff  = trial - {1'b0, div_q};
  assign rem_d = fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == STEP_W'(TOTAL_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      div_q <= divisor_i;
      quo_q <= dividend_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[TOTAL_W-2:0], fits};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ===== src/windowed_latency_statistics.sv =====
// Latency statistics over all time, a short ring and a long ring of slots.
// A request is taken when start_i is high and busy_o is low. A tick, a
// statistics clear, and a record or tick while tracking is off complete at
// the accepting edge and leave busy_o low. In a record, the
// current slot of each ring is read from its slot memory, then one shared
// merge unit updates the all-time tally, the short slot and the long slot in
// turn. In a report, each ring is walked slot by slot, with a read state
// and then a merge state per slot, through the same merge unit, and
// each of the three words waits on a bit-serial divider for
// the mean. Report words appear on valid_o for one cycle each,
// all-time first and the long window last with last_word_o set; the
// receiver cannot stall them and must take each word in its cycle.
module windowed_latency_statistics #(
  parameter int SHORT_SLOTS = 5,
  parameter int LONG_SLOTS  = 12
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [1:0]                   action_i,
  input  logic [lws_pkg::LAT_W-1:0]    latency_i,
  output logic                         valid_o,
  output logic [lws_pkg::WIN_W-1:0]    window_o,
  output logic [lws_pkg::CNT_W-1:0]    sample_count_o,
  output logic [lws_pkg::TOTAL_W-1:0]  latency_total_o,
  output logic [lws_pkg::LAT_W-1:0]    latency_least_o,
  output logic [lws_pkg::LAT_W-1:0]    latency_greatest_o,
  output logic [lws_pkg::LAT_W-1:0]    latency_mean_o,
  output logic                         last_word_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lws_pkg::ADDR_W-1:0]   paddr,
  input  logic [lws_pkg::DATA_W-1:0]   pwdata,
  output logic [lws_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);
  import lws_pkg::*;

  localparam int SIDX_W = $clog2(SHORT_SLOTS);
  localparam int LIDX_W = $clog2(LONG_SLOTS);
  localparam int PTR_W  = (SIDX_W > LIDX_W) ? SIDX_W : LIDX_W;

  state_e state_q, state_d;

  logic             enable_q;
  logic [PER_W-1:0] sper_q;
  logic [PER_W-1:0] lper_q;
  logic             cfg_wr;

  tally_t                 all_q;
  logic [SHORT_SLOTS-1:0] s_vld_q, s_vld_d;
  logic [LONG_SLOTS-1:0]  l_vld_q, l_vld_d;
  logic [SIDX_W-1:0]      sidx_q, sidx_nxt;
  logic [LIDX_W-1:0]      lidx_q, lidx_nxt;
  logic [PER_W-1:0]       stick_q, stick_inc;
  logic [PER_W-1:0]       ltick_q, ltick_inc;
  logic                   s_rot, l_rot;
  logic [LAT_W-1:0]       sample_q;
  tally_t                 acc_q;
  win_e                   win_q;
  logic [PTR_W-1:0]       ptr_q;

  tally_t            s_mem [SHORT_SLOTS];
  tally_t            l_mem [LONG_SLOTS];
  tally_t            s_rd_q, l_rd_q;
  logic              s_rd_vld_q, l_rd_vld_q;
  logic              s_rd_en, l_rd_en;
  logic [SIDX_W-1:0] s_rd_addr;
  logic [LIDX_W-1:0] l_rd_addr;
  logic              s_wr_en, l_wr_en;

  tally_t s_slot, l_slot, sample_t, mrg_a, mrg_b, mrg_y;

  logic accept, do_record, do_tick, do_clear, do_report;
  act_e act;
  logic last_slot;
  logic div_start, div_done, emit;
  logic [TOTAL_W-1:0] quotient;

  logic             valid_q;
  logic [WIN_W-1:0] window_q;
  logic [CNT_W-1:0] count_q;
  logic [TOTAL_W-1:0] total_q;
  logic [LAT_W-1:0] least_q, greatest_q, mean_q;
  logic             last_q;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b1;
      sper_q   <= PER_SHORT_RST;
      lper_q   <= PER_LONG_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_ENABLE:       enable_q <= pwdata[0];
        REG_SHORT_PERIOD: sper_q   <= pwdata[PER_W-1:0];
        REG_LONG_PERIOD:  lper_q   <= pwdata[PER_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_ENABLE:       prdata = DATA_W'(enable_q);
      REG_SHORT_PERIOD: prdata = DATA_W'(sper_q);
      REG_LONG_PERIOD:  prdata = DATA_W'(lper_q);
      default:          prdata = '0;
    endcase
  end

  // Request decode
  assign busy_o    = (state_q != ST_IDLE);
  assign accept    = start_i & ~busy_o;
  assign act       = act_e'(action_i);
  assign do_record = accept & (act == ACT_RECORD) & enable_q;
  assign do_tick   = accept & (act == ACT_TICK) & enable_q;
  assign do_clear  = accept & (act == ACT_CLEAR);
  assign do_report = accept & (act == ACT_REPORT);

  // Tick counters and ring rotation
  assign stick_inc = stick_q + 1'b1;
  assign ltick_inc = ltick_q + 1'b1;
  assign s_rot     = (stick_inc >= sper_q) | (stick_inc == '0);
  assign l_rot     = (ltick_inc >= lper_q) | (ltick_inc == '0);
  assign sidx_nxt  = (sidx_q == SIDX_W'(SHORT_SLOTS - 1)) ? '0 : sidx_q + 1'b1;
  assign lidx_nxt  = (lidx_q == LIDX_W'(LONG_SLOTS - 1)) ? '0 : lidx_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stick_q <= '0;
      ltick_q <= '0;
      sidx_q  <= '0;
      lidx_q  <= '0;
    end else if (do_tick) begin
      stick_q <= s_rot ? '0 : stick_inc;
      ltick_q <= l_rot ? '0 : ltick_inc;
      if (s_rot) begin
        sidx_q <= sidx_nxt;
      end
      if (l_rot) begin
        lidx_q <= lidx_nxt;
      end
    end
  end

  always_comb begin
    s_vld_d = s_vld_q;
    l_vld_d = l_vld_q;
    if (do_clear) begin
      s_vld_d = '0;
      l_vld_d = '0;
    end else begin
      if (do_tick && s_rot) begin
        s_vld_d[sidx_nxt] = 1'b0;
      end
      if (do_tick && l_rot) begin
        l_vld_d[lidx_nxt] = 1'b0;
      end
      if (s_wr_en) begin
        s_vld_d[sidx_q] = 1'b1;
      end
      if (l_wr_en) begin
        l_vld_d[lidx_q] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_vld_q <= '0;
      l_vld_q <= '0;
    end else begin
      s_vld_q <= s_vld_d;
      l_vld_q <= l_vld_d;
    end
  end

  // Slot memories
  always_ff @(posedge clk_i) begin
    if (s_wr_en) begin
      s_mem[sidx_q] <= mrg_y;
    end
    if (s_rd_en) begin
      s_rd_q     <= s_mem[s_rd_addr];
      s_rd_vld_q <= s_vld_q[s_rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (l_wr_en) begin
      l_mem[lidx_q] <= mrg_y;
    end
    if (l_rd_en) begin
      l_rd_q     <= l_mem[l_rd_addr];
      l_rd_vld_q <= l_vld_q[l_rd_addr];
    end
  end

  assign s_slot   = s_rd_vld_q ? s_rd_q : TALLY_RST;
  assign l_slot   = l_rd_vld_q ? l_rd_q : TALLY_RST;
  assign sample_t = '{count: CNT_W'(1), total: TOTAL_W'(sample_q),
                      least: sample_q, greatest: sample_q};

  // Shared merge unit
  always_comb begin
    case (state_q)
      ST_REC_ALL: begin
        mrg_a = all_q;
        mrg_b = sample_t;
      end
      ST_REC_SHORT: begin
        mrg_a = s_slot;
        mrg_b = sample_t;
      end
      ST_REC_LONG: begin
        mrg_a = l_slot;
        mrg_b = sample_t;
      end
      ST_MRG: begin
        mrg_a = acc_q;
        mrg_b = (win_q == WIN_SHORT) ? s_slot : l_slot;
      end
      default: begin
        mrg_a = acc_q;
        mrg_b = TALLY_RST;
      end
    endcase
  end

  assign mrg_y = tally_merge(mrg_a, mrg_b);

  assign last_slot = (win_q == WIN_SHORT) ? (ptr_q == PTR_W'(SHORT_SLOTS - 1))
                                          : (ptr_q == PTR_W'(LONG_SLOTS - 1));

  // Sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (do_record) begin
          state_d = ST_REC_ALL;
        end else if (do_report) begin
          state_d = ST_DIV_GO;
        end
      end
      ST_REC_ALL:   state_d = ST_REC_SHORT;
      ST_REC_SHORT: state_d = ST_REC_LONG;
      ST_REC_LONG:  state_d = ST_IDLE;
      ST_RD:        state_d = ST_MRG;
      ST_MRG:       state_d = last_slot ? ST_DIV_GO : ST_RD;
      ST_DIV_GO:    state_d = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (div_done) begin
          state_d = (win_q == WIN_LONG) ? ST_IDLE : ST_RD;
        end
      end
      default:      state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_rd_en   = 1'b0;
    l_rd_en   = 1'b0;
    s_rd_addr = sidx_q;
    l_rd_addr = lidx_q;
    s_wr_en   = 1'b0;
    l_wr_en   = 1'b0;
    div_start = 1'b0;
    emit      = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_rd_en = do_record;
        l_rd_en = do_record;
      end
      ST_REC_SHORT: s_wr_en = 1'b1;
      ST_REC_LONG:  l_wr_en = 1'b1;
      ST_RD: begin
        s_rd_en   = (win_q == WIN_SHORT);
        l_rd_en   = (win_q == WIN_LONG);
        s_rd_addr = ptr_q[SIDX_W-1:0];
        l_rd_addr = ptr_q[LIDX_W-1:0];
      end
      ST_DIV_GO:    div_start = 1'b1;
      ST_DIV_WAIT:  emit = div_done;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      all_q   <= TALLY_RST;
      win_q   <= WIN_ALL;
      ptr_q   <= '0;
    end else begin
      state_q <= state_d;
      if (do_clear) begin
        all_q <= TALLY_RST;
      end else if (state_q == ST_REC_ALL) begin
        all_q <= mrg_y;
      end
      if (do_report) begin
        win_q <= WIN_ALL;
      end else if (emit) begin
        case (win_q)
          WIN_ALL:   win_q <= WIN_SHORT;
          WIN_SHORT: win_q <= WIN_LONG;
          default:   win_q <= WIN_ALL;
        endcase
      end
      if (emit) begin
        ptr_q <= '0;
      end else if (state_q == ST_MRG) begin
        ptr_q <= ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_record) begin
      sample_q <= latency_i;
    end
    if (do_report) begin
      acc_q <= all_q;
    end else if (state_q == ST_MRG) begin
      acc_q <= mrg_y;
    end else if (emit) begin
      acc_q <= TALLY_RST;
    end
  end

  lws_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (acc_q.total),
    .divisor_i  (acc_q.count),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      window_q   <= win_q;
      count_q    <= acc_q.count;
      total_q    <= acc_q.total;
      least_q    <= (acc_q.count == '0) ? '0 : acc_q.least;
      greatest_q <= (acc_q.count == '0) ? '0 : acc_q.greatest;
      if (acc_q.count == '0) begin
        mean_q <= '0;
      end else if (quotient[TOTAL_W-1:LAT_W] != '0) begin
        mean_q <= LAT_MAX;
      end else begin
        mean_q <= quotient[LAT_W-1:0];
      end
      last_q     <= (win_q == WIN_LONG);
    end
  end

  assign valid_o            = valid_q;
  assign window_o           = window_q;
  assign sample_count_o     = count_q;
  assign latency_total_o    = total_q;
  assign latency_least_o    = least_q;
  assign latency_greatest_o = greatest_q;
  assign latency_mean_o     = mean_q;
  assign last_word_o        = last_q;

endmodule
